/* hw/rtl/camera_view_transform_top_assert.svh */
// ----------------------------------------------------------------------------
// camera_view_transform_top_assert.svh
// Assertion macros used by the view transform top module.
// ----------------------------------------------------------------------------
`ifndef CAMERA_VIEW_TRANSFORM_TOP_ASSERT_SVH
`define CAMERA_VIEW_TRANSFORM_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CVT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("view transform check failed");

// next-cycle implication, checked out of reset
`define CVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("view transform check failed");

`endif

/* hw/rtl/cvt_pkg.sv */
// ----------------------------------------------------------------------------
// cvt_pkg
// Shared types and constants of the camera view transform.
// ----------------------------------------------------------------------------
package cvt_pkg;

  localparam int COORD_WIDTH_DEF    = 32;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  localparam int TRIG_W   = 16;
  localparam int TRIGREG_W = 2 * TRIG_W;
  localparam int COEF_W   = TRIG_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [TRIGREG_W-1:0] TRIG_RESET = 32'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_POS_X  = 3'd0,
    CFG_CAM_POS_Y  = 3'd1,
    CFG_CAM_POS_Z  = 3'd2,
    CFG_YAW_TRIG   = 3'd3,
    CFG_PITCH_TRIG = 3'd4,
    CFG_ROLL_TRIG  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } cvt_rot_ctl_t;

endpackage

/* hw/rtl/cvt_rotate.sv */
// ----------------------------------------------------------------------------
// cvt_rotate
// Two-stage plane rotation: four registered products, then sum, floor
// shift and saturation. A third coordinate rides along unchanged.
// ----------------------------------------------------------------------------
module cvt_rotate
  import cvt_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  cvt_rot_ctl_t                  ctl,
  input  logic signed [COORD_WIDTH-1:0] a,
  input  logic signed [COORD_WIDTH-1:0] b,
  input  logic signed [COORD_WIDTH-1:0] c,
  input  logic signed [COEF_W-1:0]      k00,
  input  logic signed [COEF_W-1:0]      k01,
  input  logic signed [COEF_W-1:0]      k10,
  input  logic signed [COEF_W-1:0]      k11,
  output logic signed [COORD_WIDTH-1:0] o0,
  output logic signed [COORD_WIDTH-1:0] o1,
  output logic signed [COORD_WIDTH-1:0] oc
);

  localparam int PW = COORD_WIDTH + COEF_W;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] SAT_HI =
    {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO =
    {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic signed [PW-1:0]          p00, p01, p10, p11;
  logic signed [COORD_WIDTH-1:0] c_mul;
  logic signed [SW-1:0]          s0, s1, q0, q1, r0, r1;

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      p00   <= a * k00;
      p01   <= b * k01;
      p10   <= a * k10;
      p11   <= b * k11;
      c_mul <= c;
    end
  end

  always_comb begin
    s0 = {p00[PW-1], p00} + {p01[PW-1], p01};
    s1 = {p10[PW-1], p10} + {p11[PW-1], p11};
    q0 = s0 >>> TRIG_FRAC_BITS;
    q1 = s1 >>> TRIG_FRAC_BITS;
    r0 = (q0 > SAT_HI) ? SAT_HI : ((q0 < SAT_LO) ? SAT_LO : q0);
    r1 = (q1 > SAT_HI) ? SAT_HI : ((q1 < SAT_LO) ? SAT_LO : q1);
  end

  always_ff @(posedge clk) begin
    if (ctl.en_sum) begin
      o0 <= r0[COORD_WIDTH-1:0];
      o1 <= r1[COORD_WIDTH-1:0];
      oc <= c_mul;
    end
  end

endmodule

/* hw/rtl/camera_view_transform_top.sv */
// ----------------------------------------------------------------------------
// camera_view_transform_top
// World-space to camera-space vertex transform: translate, then rotate by
// minus roll, minus pitch and minus yaw, saturating at every step.
//
//   channel   direction   handshake             payload
//   vertex    in          in_valid / in_stall   vertex_x, vertex_y, vertex_z
//   view      out         out_valid / out_stall view_x, view_y, view_z
//   config    in          cfg_we                cfg_index, cfg_data
//
// Seven register stages: translate, then multiply and sum for each of the
// three rotations. One vertex enters per cycle while in_stall is low.
// Each stage holds while the next one is full and stalled, so bubbles
// collapse and a stall loses nothing. Reset clears the valid bits and
// loads the identity camera.
// ----------------------------------------------------------------------------
`include "camera_view_transform_top_assert.svh"

module camera_view_transform_top
  import cvt_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  localparam int CFG_W = (COORD_WIDTH > TRIGREG_W) ? COORD_WIDTH : TRIGREG_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] vertex_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] view_x,
  output logic signed [COORD_WIDTH-1:0] view_y,
  output logic signed [COORD_WIDTH-1:0] view_z
);

  localparam int NSTAGE = 7;
  localparam int DW = COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] cam_pos_x, cam_pos_y, cam_pos_z;
  logic [TRIGREG_W-1:0]          yaw_trig, pitch_trig, roll_trig;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  logic signed [COORD_WIDTH-1:0] tx, ty, tz;
  logic signed [COORD_WIDTH-1:0] x1, y1, z1;
  logic signed [COORD_WIDTH-1:0] y2, z2, x2;
  logic signed [DW-1:0]          dx, dy, dz;

  logic signed [COEF_W-1:0] cr, sr, nsr, cp, sp, nsp, cy, sy, nsy;

  cvt_rot_ctl_t roll_ctl, pitch_ctl, yaw_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_pos_x  <= '0;
      cam_pos_y  <= '0;
      cam_pos_z  <= '0;
      yaw_trig   <= TRIG_RESET;
      pitch_trig <= TRIG_RESET;
      roll_trig  <= TRIG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAM_POS_X:  cam_pos_x  <= cfg_data[COORD_WIDTH-1:0];
        CFG_CAM_POS_Y:  cam_pos_y  <= cfg_data[COORD_WIDTH-1:0];
        CFG_CAM_POS_Z:  cam_pos_z  <= cfg_data[COORD_WIDTH-1:0];
        CFG_YAW_TRIG:   yaw_trig   <= cfg_data[TRIGREG_W-1:0];
        CFG_PITCH_TRIG: pitch_trig <= cfg_data[TRIGREG_W-1:0];
        CFG_ROLL_TRIG:  roll_trig  <= cfg_data[TRIGREG_W-1:0];
        default: ;
      endcase
    end
  end

  // cosine and sine, sign-extended so that a negated sine stays exact
  always_comb begin
    cr  = {roll_trig[TRIGREG_W-1], roll_trig[TRIGREG_W-1:TRIG_W]};
    sr  = {roll_trig[TRIG_W-1], roll_trig[TRIG_W-1:0]};
    cp  = {pitch_trig[TRIGREG_W-1], pitch_trig[TRIGREG_W-1:TRIG_W]};
    sp  = {pitch_trig[TRIG_W-1], pitch_trig[TRIG_W-1:0]};
    cy  = {yaw_trig[TRIGREG_W-1], yaw_trig[TRIGREG_W-1:TRIG_W]};
    sy  = {yaw_trig[TRIG_W-1], yaw_trig[TRIG_W-1:0]};
    nsr = -sr;
    nsp = -sp;
    nsy = -sy;
  end

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // translate and saturate
  always_comb begin
    dx = {vertex_x[COORD_WIDTH-1], vertex_x} - {cam_pos_x[COORD_WIDTH-1], cam_pos_x};
    dy = {vertex_y[COORD_WIDTH-1], vertex_y} - {cam_pos_y[COORD_WIDTH-1], cam_pos_y};
    dz = {vertex_z[COORD_WIDTH-1], vertex_z} - {cam_pos_z[COORD_WIDTH-1], cam_pos_z};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tx <= (dx[DW-1] != dx[DW-2]) ? {dx[DW-1], {(COORD_WIDTH-1){!dx[DW-1]}}}
                                   : dx[COORD_WIDTH-1:0];
      ty <= (dy[DW-1] != dy[DW-2]) ? {dy[DW-1], {(COORD_WIDTH-1){!dy[DW-1]}}}
                                   : dy[COORD_WIDTH-1:0];
      tz <= (dz[DW-1] != dz[DW-2]) ? {dz[DW-1], {(COORD_WIDTH-1){!dz[DW-1]}}}
                                   : dz[COORD_WIDTH-1:0];
    end
  end

  assign roll_ctl  = '{en_mul: en[1], en_sum: en[2]};
  assign pitch_ctl = '{en_mul: en[3], en_sum: en[4]};
  assign yaw_ctl   = '{en_mul: en[5], en_sum: en[6]};

  // roll: x1 = x*cr + y*sr, y1 = x*(-sr) + y*cr
  cvt_rotate #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_roll (
    .clk(clk), .ctl(roll_ctl),
    .a(tx), .b(ty), .c(tz),
    .k00(cr), .k01(sr), .k10(nsr), .k11(cr),
    .o0(x1), .o1(y1), .oc(z1)
  );

  // pitch: y2 = y1*cp + z*sp, z2 = y1*(-sp) + z*cp
  cvt_rotate #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_pitch (
    .clk(clk), .ctl(pitch_ctl),
    .a(y1), .b(z1), .c(x1),
    .k00(cp), .k01(sp), .k10(nsp), .k11(cp),
    .o0(y2), .o1(z2), .oc(x2)
  );

  // yaw: vx = x1*cy + z2*(-sy), vz = x1*sy + z2*cy
  cvt_rotate #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_yaw (
    .clk(clk), .ctl(yaw_ctl),
    .a(x2), .b(z2), .c(y2),
    .k00(cy), .k01(nsy), .k10(sy), .k11(cy),
    .o0(view_x), .o1(view_z), .oc(view_y)
  );

  `CVT_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, vld[0])
  `CVT_ASSERT_NOW(a_stall_only_full, in_stall, (&vld) && out_stall)
  `CVT_ASSERT_NEXT(a_held_stage_kept, vld[3] && !en[3], vld[3])

endmodule

/* test/camera_view_transform_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_view_transform_top_tb
// Feeds world-space vertices through the view transform and checks each
// camera-space result. Expected results come from a behavioral model of the
// saturating translate and roll, pitch, yaw rotation. The model is run on every
// accepted vertex that has no typed expectation. A short directed table covers
// the reset camera, the saturation corners, unnormalized and extreme cos/sin
// pairs, and writes to unused register indexes. Random phases then reprogram
// the camera and stream vertices in bursts while the output side stalls at
// random, with one long output hold that backs the pipe up into its input.
// ----------------------------------------------------------------------------
module camera_view_transform_top_tb;
  import cvt_pkg::*;

  localparam int     CW            = COORD_WIDTH_DEF;
  localparam int     FRAC          = TRIG_FRAC_BITS_DEF;
  localparam int     RESET_CYCLES  = 9;
  localparam int     RANDOM_PHASES = 10;
  localparam int     PHASE_ITEMS   = 75;
  localparam int     HOLD_CYCLES   = 60;
  localparam int     TAIL_CYCLES   = 20;
  localparam int     MAX_REPORTS   = 10;
  localparam longint TIMEOUT_NS    = 4_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam logic [TRIGREG_W-1:0] TRIG_ROLL_90  = 32'h0000_4000;
  localparam logic [TRIGREG_W-1:0] TRIG_NEG_FULL = 32'h8000_8000;
  localparam logic [TRIGREG_W-1:0] TRIG_POS_FULL = 32'h7FFF_7FFF;
  localparam logic [TRIGREG_W-1:0] TRIG_NEG_COS  = 32'hC000_0000;
  localparam logic [TRIGREG_W-1:0] TRIG_DIAG     = 32'h2D41_D2BF;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] idx;
    logic [TRIGREG_W-1:0] data;
    vec3_t                vtx;
    bit                   typed;
    vec3_t                want;
  } step_t;

  localparam coord_t C_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam longint SAT_HI = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TRIGREG_W-1:0] cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  coord_t               vertex_x  = '0;
  coord_t               vertex_y  = '0;
  coord_t               vertex_z  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  coord_t               view_x;
  coord_t               view_y;
  coord_t               view_z;

  longint               cam_x    = 0;
  longint               cam_y    = 0;
  longint               cam_z    = 0;
  logic [TRIGREG_W-1:0] yaw_cs   = TRIG_RESET;
  logic [TRIGREG_W-1:0] pitch_cs = TRIG_RESET;
  logic [TRIGREG_W-1:0] roll_cs  = TRIG_RESET;

  vec3_t pending_views[$];
  step_t directed_steps[$];
  vec3_t view_want;

  int mismatch_count     = 0;
  int views_seen         = 0;
  int vertices_sent      = 0;
  int directed_count     = 0;
  int reg_writes         = 0;
  int input_stall_cycles = 0;
  int burst_left         = 0;
  int gap_len            = 0;
  bit hold_request       = 1'b0;

  camera_view_transform_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .vertex_x  (vertex_x),
    .vertex_y  (vertex_y),
    .vertex_z  (vertex_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .view_x    (view_x),
    .view_y    (view_y),
    .view_z    (view_z)
  );

  always #10 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic vec3_t vec(coord_t x, coord_t y, coord_t z);
    return {x, y, z};
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint trig_cos(logic [TRIGREG_W-1:0] t);
    logic signed [TRIG_W-1:0] h;
    h = t[TRIGREG_W-1:TRIG_W];
    return h;
  endfunction

  function automatic longint trig_sin(logic [TRIGREG_W-1:0] t);
    logic signed [TRIG_W-1:0] h;
    h = t[TRIG_W-1:0];
    return h;
  endfunction

  // floor of the exact product sum, then clamp
  function automatic longint rot_term(longint a, longint ka, longint b, longint kb);
    return clamp_coord((a * ka + b * kb) >>> FRAC);
  endfunction

  function automatic vec3_t predict_view(vec3_t v);
    longint cy, sy, cp, sp, cr, sr;
    longint x, y, z, x1, y1, y2, z2, vx, vz;
    vec3_t  r;
    cy = trig_cos(yaw_cs);
    sy = trig_sin(yaw_cs);
    cp = trig_cos(pitch_cs);
    sp = trig_sin(pitch_cs);
    cr = trig_cos(roll_cs);
    sr = trig_sin(roll_cs);
    x  = clamp_coord(longint'(v.x) - cam_x);
    y  = clamp_coord(longint'(v.y) - cam_y);
    z  = clamp_coord(longint'(v.z) - cam_z);
    x1 = rot_term(x, cr, y, sr);
    y1 = rot_term(x, -sr, y, cr);
    y2 = rot_term(y1, cp, z, sp);
    z2 = rot_term(y1, -sp, z, cp);
    vx = rot_term(x1, cy, z2, -sy);
    vz = rot_term(x1, sy, z2, cy);
    r.x = vx[CW-1:0];
    r.y = y2[CW-1:0];
    r.z = vz[CW-1:0];
    return r;
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx,
                                      logic [TRIGREG_W-1:0] data);
    case (idx)
      CFG_CAM_POS_X:  cam_x = coord_t'(data[CW-1:0]);
      CFG_CAM_POS_Y:  cam_y = coord_t'(data[CW-1:0]);
      CFG_CAM_POS_Z:  cam_z = coord_t'(data[CW-1:0]);
      CFG_YAW_TRIG:   yaw_cs = data;
      CFG_PITCH_TRIG: pitch_cs = data;
      CFG_ROLL_TRIG:  roll_cs = data;
      default: ;
    endcase
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return C_MAX;
      1: return C_MIN;
      2: return coord_t'($urandom_range(0, 2)) - 1;
      3, 4, 5, 6: return coord_t'($urandom_range(0, 1 << 24)) - (1 << 23);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TRIGREG_W-1:0] rand_trig();
    logic [TRIG_W-1:0] c, s;
    c = TRIG_W'($urandom_range(0, 32768) - 16384);
    s = TRIG_W'($urandom_range(0, 32768) - 16384);
    case ($urandom_range(0, 7))
      0: return TRIG_RESET;
      1: return TRIG_NEG_FULL;
      2: return TRIG_POS_FULL;
      3, 4, 5: return {c, s};
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [TRIGREG_W-1:0] data);
    step_t s;
    s = '{default: '0};
    s.is_write = 1'b1;
    s.idx      = idx;
    s.data     = data;
    directed_steps.push_back(s);
  endfunction

  function automatic void add_vertex(vec3_t v, bit typed = 1'b0, vec3_t want = '0);
    step_t s;
    s = '{default: '0};
    s.vtx   = v;
    s.typed = typed;
    s.want  = want;
    directed_steps.push_back(s);
  endfunction

  function automatic void build_table();
    add_vertex(vec(0, 0, 0), 1'b1, vec(0, 0, 0));
    add_vertex(vec(C_MAX, C_MIN, -1), 1'b1, vec(C_MAX, C_MIN, -1));
    add_vertex(vec(C_MIN, C_MAX, 1), 1'b1, vec(C_MIN, C_MAX, 1));
    add_vertex(vec(32'sh1234_5678, 32'shEDCB_A987, 32'sh0001_0000), 1'b1,
               vec(32'sh1234_5678, 32'shEDCB_A987, 32'sh0001_0000));
    add_write(CFG_CAM_POS_X, C_MAX);
    add_write(CFG_CAM_POS_Y, C_MIN);
    add_write(CFG_CAM_POS_Z, 1);
    add_vertex(vec(C_MIN, C_MAX, C_MIN), 1'b1, vec(C_MIN, C_MAX, C_MIN));
    add_vertex(vec(C_MAX, C_MIN, 0), 1'b1, vec(0, 0, -1));
    add_vertex(vec(-1, -2, 1), 1'b1, vec(C_MIN, C_MAX - 1, 0));
    add_write(CFG_CAM_POS_X, 0);
    add_write(CFG_CAM_POS_Y, 0);
    add_write(CFG_CAM_POS_Z, 0);
    add_write(CFG_ROLL_TRIG, TRIG_ROLL_90);
    add_vertex(vec(32'sh0005_0000, 32'sh0007_0000, 32'sh0009_0000));
    add_vertex(vec(C_MAX, C_MIN, C_MAX));
    add_write(CFG_PITCH_TRIG, TRIG_NEG_FULL);
    add_write(CFG_YAW_TRIG, TRIG_POS_FULL);
    add_vertex(vec(C_MAX, C_MAX, C_MAX));
    add_vertex(vec(C_MIN, C_MIN, C_MIN));
    add_vertex(vec(1, -1, 1));
    add_vertex(vec(-1, -1, -1));
    add_write(CFG_ROLL_TRIG, TRIG_NEG_FULL);
    add_write(CFG_YAW_TRIG, TRIG_NEG_COS);
    add_write(CFG_PITCH_TRIG, TRIG_DIAG);
    add_vertex(vec(32'sh0003_8000, -32'sh0001_4000, 32'sh7FFF_0000));
    add_vertex(vec(C_MIN, 0, C_MAX));
    // spare indexes must leave the camera untouched
    add_write(CFG_SPARE_6, '1);
    add_write(CFG_SPARE_7, '1);
    add_vertex(vec(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    add_write(CFG_CAM_POS_X, -1);
    add_write(CFG_CAM_POS_Z, C_MIN);
    add_vertex(vec(C_MIN, C_MIN, C_MAX));
  endfunction

  task automatic log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic check_field(string name, coord_t want, coord_t got);
    if (got !== want)
      log_mismatch($sformatf("view %0d %s: expected %0d (%h), got %0d (%h)",
                             views_seen, name, want, want, got, got));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TRIGREG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_write(idx, data);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // hold the request until it is taken, then maybe drop into a gap
  task automatic push_vertex(vec3_t v, bit typed, vec3_t want);
    in_valid <= 1'b1;
    vertex_x <= v.x;
    vertex_y <= v.y;
    vertex_z <= v.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_views.push_back(typed ? want : predict_view(v));
    vertices_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap_len    = $urandom_range(0, 5);
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      views_seen++;
      if (pending_views.size() == 0) begin
        log_mismatch($sformatf("view %0d: nothing pending, got (%0d, %0d, %0d)",
                               views_seen, view_x, view_y, view_z));
      end else begin
        view_want = pending_views.pop_front();
        check_field("view_x", view_want.x, view_x);
        check_field("view_y", view_want.y, view_y);
        check_field("view_z", view_want.z, view_z);
      end
    end
  end

  initial begin : receiver
    int seg;
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 80);
      repeat (seg) begin
        if (hold_request) begin
          hold_request = 1'b0;
          repeat (HOLD_CYCLES) begin
            out_stall <= 1'b1;
            @(posedge clk);
            if (in_stall) input_stall_cycles++;
          end
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 7) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    step_t row;
    build_table();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.is_write) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        push_vertex(row.vtx, row.typed, row.want);
      end
    end
    directed_count = vertices_sent;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      for (int r = CFG_CAM_POS_X; r <= CFG_ROLL_TRIG; r++)
        if (p == 0 || $urandom_range(0, 1))
          write_reg(r[CFG_IDX_W-1:0], (r <= CFG_CAM_POS_Z) ? rand_coord() : rand_trig());
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, $urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == 20) hold_request = 1'b1;
        push_vertex(vec(rand_coord(), rand_coord(), rand_coord()), 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d vertices (%0d directed) across %0d register writes; %0d views checked.",
             vertices_sent, directed_count, reg_writes, views_seen);
    $display("Long output hold backed up the input for %0d cycles; %0d mismatches.",
             input_stall_cycles, mismatch_count);
    if (mismatch_count == 0 && pending_views.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/cvt_pkg.sv
hw/rtl/cvt_rotate.sv
hw/rtl/camera_view_transform_top.sv
test/camera_view_transform_top_tb.sv
